[rtl/prht_pkg.sv]
package prht_pkg;

  // APB register map, one 32-bit word per register
  localparam int APB_ADDR_BITS = 4;
  localparam int APB_DATA_BITS = 32;

  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_BOTTOM = 2'd1,
    REG_RIGHT  = 2'd2,
    REG_TOP    = 2'd3
  } reg_idx_t;

  // Outcode bits
  typedef logic [3:0] outcode_t;
  localparam outcode_t OC_LEFT   = 4'd1;
  localparam outcode_t OC_RIGHT  = 4'd2;
  localparam outcode_t OC_BOTTOM = 4'd4;
  localparam outcode_t OC_TOP    = 4'd8;

  // Clip passes per edge before it counts as a miss
  localparam int PASS_LIMIT = 8;
  localparam int PASS_BITS  = $clog2(PASS_LIMIT + 1);

  typedef enum logic [2:0] {
    T_IDLE,
    T_RUN1,
    T_WAIT1,
    T_RUN2,
    T_WAIT2,
    T_FIN
  } top_state_t;

  typedef enum logic [1:0] {
    E_IDLE,
    E_TEST,
    E_MUL,
    E_DIV
  } edge_state_t;

  typedef struct packed {
    logic done;
    logic hit;
  } edge_status_t;

endpackage

[rtl/polyline_rect_hit_test.sv]
// Channel   Direction  Handshake            Payload
// config    in         psel/penable/pready  paddr, pwrite, pwdata, prdata
// vertex    in         in_valid/in_stall    vertex_x, vertex_y, last_vertex
// result    out        out_valid/out_stall  hit
//
// A vertex that opens a polyline, or follows a hit, is taken without an edge test to
// the vertex before it. Each edge test makes at most eight clip passes through the
// serial divider in the edge unit. The last vertex then tests the closing edge to the
// first vertex, unless a hit is already known, and loads the result register.
// Reset (rst, synchronous) clears the bounds, the polyline state and the result valid.
// in_stall stays high while an item is in work; a stalled result holds in its
// register while the next vertex is taken.
module polyline_rect_hit_test import prht_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  // APB configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_ADDR_BITS-1:0]     paddr,
  input  logic [APB_DATA_BITS-1:0]     pwdata,
  output logic [APB_DATA_BITS-1:0]     prdata,
  output logic                         pready,
  // vertex requests
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] vertex_x,
  input  logic signed [COORD_BITS-1:0] vertex_y,
  input  logic                         last_vertex,
  // result requests
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         hit
);

  top_state_t state, state_next;

  logic signed [COORD_BITS-1:0] rect_left, rect_bottom, rect_right, rect_top;
  logic signed [COORD_BITS-1:0] first_x, first_y, prev_x, prev_y, cur_x, cur_y;
  logic                         cur_last;
  logic                         have_prev, any_hit;

  logic                         in_accept, out_load, cfg_write;
  reg_idx_t                     reg_idx;

  logic                         edge_start;
  logic signed [COORD_BITS-1:0] ex1, ey1, ex2, ey2;
  edge_status_t                 edge_status;

  // Configuration registers
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      rect_left   <= '0;
      rect_bottom <= '0;
      rect_right  <= '0;
      rect_top    <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_LEFT:   rect_left   <= pwdata[COORD_BITS-1:0];
        REG_BOTTOM: rect_bottom <= pwdata[COORD_BITS-1:0];
        REG_RIGHT:  rect_right  <= pwdata[COORD_BITS-1:0];
        REG_TOP:    rect_top    <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read back sign-extended
  always_comb begin
    unique case (reg_idx)
      REG_LEFT:   prdata = APB_DATA_BITS'(rect_left);
      REG_BOTTOM: prdata = APB_DATA_BITS'(rect_bottom);
      REG_RIGHT:  prdata = APB_DATA_BITS'(rect_right);
      REG_TOP:    prdata = APB_DATA_BITS'(rect_top);
      default:    prdata = '0;
    endcase
  end

  // Take a vertex only when idle; the result register is separate
  assign in_stall  = rst || (state != T_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state == T_FIN) && (!out_valid || !out_stall);

  // Edge operands: the clipped end comes first
  always_comb begin
    if (state == T_RUN2) begin
      ex1 = first_x; ey1 = first_y; ex2 = cur_x; ey2 = cur_y;
    end else begin
      ex1 = cur_x;   ey1 = cur_y;   ex2 = prev_x; ey2 = prev_y;
    end
  end

  always_comb begin
    state_next = state;
    edge_start = 1'b0;
    unique case (state)
      T_IDLE: begin
        if (in_accept) begin
          if (!have_prev) state_next = last_vertex ? T_RUN2 : T_IDLE;
          else if (any_hit) state_next = last_vertex ? T_FIN : T_IDLE;
          else state_next = T_RUN1;
        end
      end
      T_RUN1: begin
        edge_start = 1'b1;
        state_next = T_WAIT1;
      end
      T_WAIT1: if (edge_status.done) state_next = cur_last ? T_RUN2 : T_IDLE;
      T_RUN2: begin
        // skip the closing edge once something already hit
        edge_start = !any_hit;
        state_next = any_hit ? T_FIN : T_WAIT2;
      end
      T_WAIT2: if (edge_status.done) state_next = T_FIN;
      T_FIN:   if (out_load) state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      have_prev <= 1'b0;
      any_hit   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_accept && !have_prev) have_prev <= 1'b1;
      if ((state == T_WAIT1 || state == T_WAIT2) && edge_status.done) begin
        any_hit <= any_hit | edge_status.hit;
      end
      if (out_load) begin
        have_prev <= 1'b0;
        any_hit   <= 1'b0;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cur_x    <= vertex_x;
      cur_y    <= vertex_y;
      cur_last <= last_vertex;
      if (!have_prev) begin
        first_x <= vertex_x;
        first_y <= vertex_y;
      end
      // advance prev now when no edge test follows
      if (!have_prev || any_hit) begin
        prev_x <= vertex_x;
        prev_y <= vertex_y;
      end
    end
    if (state == T_WAIT1 && edge_status.done) begin
      prev_x <= cur_x;
      prev_y <= cur_y;
    end
    if (out_load) hit <= any_hit;
  end

  prht_edge #(
    .COORD_BITS(COORD_BITS)
  ) u_edge (
    .clk        (clk),
    .rst        (rst),
    .start      (edge_start),
    .x1_in      (ex1),
    .y1_in      (ey1),
    .x2_in      (ex2),
    .y2_in      (ey2),
    .rect_left  (rect_left),
    .rect_bottom(rect_bottom),
    .rect_right (rect_right),
    .rect_top   (rect_top),
    .status     (edge_status)
  );

endmodule

[rtl/prht_div.sv]
module prht_div import prht_pkg::*; #(
  parameter int DIVIDEND_BITS = 34,
  parameter int DIVISOR_BITS  = 17
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [DIVISOR_BITS-1:0]  divisor,
  output logic                     done,
  output logic [DIVIDEND_BITS-1:0] quotient
);

  localparam int CNT_BITS = (DIVIDEND_BITS > 1) ? $clog2(DIVIDEND_BITS) : 1;

  logic                    busy;
  logic [CNT_BITS-1:0]     cnt;
  logic [DIVISOR_BITS-1:0] rem;
  logic [DIVISOR_BITS-1:0] dsr;
  logic [DIVISOR_BITS:0]   trial;
  logic                    ge;

  // Restoring division: one quotient bit per cycle
  assign trial = {rem, quotient[DIVIDEND_BITS-1]};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_BITS'(1);
        if (cnt == CNT_BITS'(DIVIDEND_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? DIVISOR_BITS'(trial - {1'b0, dsr}) : trial[DIVISOR_BITS-1:0];
      quotient <= {quotient[DIVIDEND_BITS-2:0], ge};
    end
  end

endmodule

[rtl/prht_edge.sv]
module prht_edge import prht_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [COORD_BITS-1:0] x1_in,
  input  logic signed [COORD_BITS-1:0] y1_in,
  input  logic signed [COORD_BITS-1:0] x2_in,
  input  logic signed [COORD_BITS-1:0] y2_in,
  input  logic signed [COORD_BITS-1:0] rect_left,
  input  logic signed [COORD_BITS-1:0] rect_bottom,
  input  logic signed [COORD_BITS-1:0] rect_right,
  input  logic signed [COORD_BITS-1:0] rect_top,
  output edge_status_t                 status
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] COORD_MAX = SW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] COORD_MIN = -COORD_MAX - SW'(1);

  function automatic outcode_t outcode(
    input logic signed [COORD_BITS-1:0] x,
    input logic signed [COORD_BITS-1:0] y,
    input logic signed [COORD_BITS-1:0] l,
    input logic signed [COORD_BITS-1:0] b,
    input logic signed [COORD_BITS-1:0] r,
    input logic signed [COORD_BITS-1:0] t
  );
    outcode_t c;
    c = '0;
    if (x > r) c = OC_RIGHT;
    else if (x < l) c = OC_LEFT;
    if (y > t) c = c | OC_TOP;
    else if (y < b) c = c | OC_BOTTOM;
    return c;
  endfunction

  function automatic logic single_bit(input outcode_t c);
    return (c != '0) && ((c & (c - 4'd1)) == '0);
  endfunction

  function automatic logic [DW-1:0] magn(input logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  edge_state_t state, state_next;

  logic signed [COORD_BITS-1:0] x1, y1, x2, y2;
  logic [PASS_BITS-1:0]         pass;
  logic [DW-1:0]                d_mag, b_mag, den_mag;
  logic                         neg, den_zero, clip_x;
  logic signed [COORD_BITS-1:0] base, bound;

  outcode_t c1, c2;
  logic     reject, accept, at_limit, finish;

  logic signed [DW-1:0]         dx, dy, sel_d, sel_b, sel_den;
  logic signed [COORD_BITS-1:0] sel_base, sel_bound;
  logic                         sel_clip_x;

  logic          div_start, div_done;
  logic [PW-1:0] dividend, quotient;

  logic signed [SW-1:0]         raw;
  logic signed [COORD_BITS-1:0] moved;

  assign c1       = outcode(x1, y1, rect_left, rect_bottom, rect_right, rect_top);
  assign c2       = outcode(x2, y2, rect_left, rect_bottom, rect_right, rect_top);
  assign reject   = (c1 & c2) != '0;
  assign accept   = (c1 == '0) || (c2 == '0) ||
                    (single_bit(c1) && single_bit(c2) &&
                     (((c1 ^ c2) == (OC_LEFT | OC_RIGHT)) ||
                      ((c1 ^ c2) == (OC_TOP | OC_BOTTOM))));
  assign at_limit = pass == PASS_BITS'(PASS_LIMIT);
  assign finish   = at_limit || reject || accept;

  assign dx = DW'(x2) - DW'(x1);
  assign dy = DW'(y2) - DW'(y1);

  // Pick the boundary: top, bottom, right, left
  always_comb begin
    if ((c1 & OC_TOP) != '0) begin
      sel_d = dx; sel_b = DW'(rect_top) - DW'(y1); sel_den = dy;
      sel_base = x1; sel_bound = rect_top; sel_clip_x = 1'b1;
    end else if ((c1 & OC_BOTTOM) != '0) begin
      sel_d = dx; sel_b = DW'(rect_bottom) - DW'(y1); sel_den = dy;
      sel_base = x1; sel_bound = rect_bottom; sel_clip_x = 1'b1;
    end else if ((c1 & OC_RIGHT) != '0) begin
      sel_d = dy; sel_b = DW'(rect_right) - DW'(x1); sel_den = dx;
      sel_base = y1; sel_bound = rect_right; sel_clip_x = 1'b0;
    end else begin
      sel_d = dy; sel_b = DW'(rect_left) - DW'(x1); sel_den = dx;
      sel_base = y1; sel_bound = rect_left; sel_clip_x = 1'b0;
    end
  end

  // Product feeds the divider's input register directly
  assign dividend = PW'(d_mag * b_mag);

  prht_div #(
    .DIVIDEND_BITS(PW),
    .DIVISOR_BITS (DW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(dividend),
    .divisor (den_mag),
    .done    (div_done),
    .quotient(quotient)
  );

  // Move along the edge and saturate to the coordinate range
  always_comb begin
    raw = neg ? (SW'(base) - SW'(quotient)) : (SW'(base) + SW'(quotient));
    if (den_zero) moved = base;
    else if (raw > COORD_MAX) moved = COORD_MAX[COORD_BITS-1:0];
    else if (raw < COORD_MIN) moved = COORD_MIN[COORD_BITS-1:0];
    else moved = raw[COORD_BITS-1:0];
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      E_IDLE: if (start) state_next = E_TEST;
      E_TEST: state_next = finish ? E_IDLE : E_MUL;
      E_MUL: begin
        div_start  = 1'b1;
        state_next = E_DIV;
      end
      E_DIV: if (div_done) state_next = E_TEST;
      default: state_next = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= E_IDLE;
      status <= '0;
    end else begin
      state       <= state_next;
      status.done <= 1'b0;
      if (state == E_TEST && finish) begin
        status.done <= 1'b1;
        status.hit  <= !at_limit && !reject && accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      E_IDLE: begin
        if (start) begin
          x1   <= x1_in;
          y1   <= y1_in;
          x2   <= x2_in;
          y2   <= y2_in;
          pass <= '0;
        end
      end
      E_TEST: begin
        d_mag    <= magn(sel_d);
        b_mag    <= magn(sel_b);
        den_mag  <= magn(sel_den);
        neg      <= sel_d[DW-1] ^ sel_b[DW-1] ^ sel_den[DW-1];
        den_zero <= sel_den == '0;
        base     <= sel_base;
        bound    <= sel_bound;
        clip_x   <= sel_clip_x;
      end
      E_MUL: ;
      E_DIV: begin
        if (div_done) begin
          pass <= pass + PASS_BITS'(1);
          if (clip_x) begin
            x1 <= moved;
            y1 <= bound;
          end else begin
            y1 <= moved;
            x1 <= bound;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

[rtl/prht_checker.sv]
module prht_checker (
  input logic clk,
  input logic rst,
  input logic psel,
  input logic penable,
  input logic pwrite,
  input logic pready,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic hit
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hit))
    else $error("stalled result changed");

  // a result only rises right after vertex requests were held off
  a_out_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a finishing cycle");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid survived reset");

  a_pready: assert property (@(posedge clk) disable iff (rst)
    psel && penable |-> pready)
    else $error("config access was not ready");

endmodule

bind polyline_rect_hit_test prht_checker u_prht_checker (.*);

[verif/tb_polyline_rect_hit_test.sv]
module tb_polyline_rect_hit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import prht_pkg::*;

  localparam int COORD_W = 16;
  // One edge test: setup plus up to PASS_LIMIT clip passes on the serial divider.
  localparam int EDGE_CYCLES = 2 + PASS_LIMIT * (2 * COORD_W + 5);
  // Worst case for one vertex: the edge to the previous vertex and the closing edge.
  localparam int SETTLE_CYCLES = 2 * EDGE_CYCLES + 16;
  localparam int CYCLE_LIMIT = 6_000_000;
  localparam int HOLD_CYCLES = 3000;
  localparam int PHASES = 12;
  localparam int PHASE_VERTICES = 125;
  localparam longint COORD_HI = 32767;
  localparam longint COORD_LO = -32768;
  localparam longint unsigned QUOT_CAP = 64'd1 << 40;

  typedef enum {ROW_VERTEX, ROW_RECT} row_kind_e;

  // Vertex rows: a = x, b = y. Rect rows: a..d = left, bottom, right, top.
  typedef struct {
    row_kind_e kind;
    int        a;
    int        b;
    int        c;
    int        d;
    bit        last;
    bit        known;
    bit        hit;
  } plan_row_t;

  localparam int PLAN_ROWS = 22;

  logic                      clk;
  logic                      rst;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [APB_ADDR_BITS-1:0]  paddr;
  logic [APB_DATA_BITS-1:0]  pwdata;
  logic [APB_DATA_BITS-1:0]  prdata;
  logic                      pready;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [COORD_W-1:0] vertex_x;
  logic signed [COORD_W-1:0] vertex_y;
  logic                      last_vertex;
  logic                      out_valid;
  logic                      out_stall;
  logic                      hit;

  // Pick window as the block should hold it.
  longint win_left, win_bottom, win_right, win_top;
  // Polyline tracking, mirrors the block's own state.
  longint poly_first_x, poly_first_y, poly_prev_x, poly_prev_y;
  bit     poly_open, poly_hit;

  // Hit flags still owed by the block, oldest first.
  bit     pending_hits[$];
  int     faults;
  int     cycle_count;

  // Idle knobs, set per phase by the stimulus process.
  int     gap_pct;
  int     stall_pct;
  bit     hold_pending;
  bit     hold_taken;
  int     hold_left;

  plan_row_t plan [0:PLAN_ROWS-1] = '{
    // Reset window is the single point (0,0).
    '{ROW_VERTEX,      0,      0, 0, 0, 1, 1, 1},  // lone vertex on the point
    '{ROW_VERTEX,  32767, -32768, 0, 0, 1, 1, 0},  // lone vertex far outside
    '{ROW_VERTEX,     -5,      0, 0, 0, 0, 0, 0},
    '{ROW_VERTEX,      5,      0, 0, 0, 1, 1, 1},  // straddles left and right
    '{ROW_VERTEX, -32768, -32768, 0, 0, 0, 0, 0},
    '{ROW_VERTEX,  32767,  32767, 0, 0, 1, 0, 0},  // full diagonal, clipped once
    '{ROW_RECT,     -100,    -50, 200, 150, 0, 0, 0},
    '{ROW_VERTEX,    250,    200, 0, 0, 0, 0, 0},
    '{ROW_VERTEX,    300,    160, 0, 0, 0, 0, 0},
    '{ROW_VERTEX,    210,    300, 0, 0, 1, 0, 0},  // triangle beyond the corner
    '{ROW_VERTEX,   -200,      0, 0, 0, 0, 0, 0},
    '{ROW_VERTEX,      0,    300, 0, 0, 0, 0, 0},
    '{ROW_VERTEX,   -300,    300, 0, 0, 1, 0, 0},  // edges cutting near a corner
    '{ROW_VERTEX,     50,     60, 0, 0, 1, 1, 1},  // lone vertex inside
    '{ROW_RECT,      100,    100, -100, -100, 0, 0, 0},  // inverted window
    '{ROW_VERTEX,      0,      0, 0, 0, 1, 0, 0},
    '{ROW_VERTEX,   -200,   -200, 0, 0, 0, 0, 0},
    '{ROW_VERTEX,    200,    200, 0, 0, 1, 0, 0},
    '{ROW_RECT,   -32768, -32768, 32767, 32767, 0, 0, 0},  // whole plane
    '{ROW_VERTEX,  32767,  32767, 0, 0, 0, 0, 0},
    '{ROW_VERTEX, -32768, -32768, 0, 0, 1, 1, 1},
    '{ROW_VERTEX,      0, -32768, 0, 0, 1, 1, 1}
  };

  polyline_rect_hit_test #(.COORD_BITS(COORD_W)) DUT (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .vertex_x    (vertex_x),
    .vertex_y    (vertex_y),
    .last_vertex (last_vertex),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Hit prediction
  // ---------------------------------------------------------------------------

  function automatic longint clamp_coord(longint v);
    if (v > COORD_HI) return COORD_HI;
    if (v < COORD_LO) return COORD_LO;
    return v;
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic outcode_t window_code(longint x, longint y);
    outcode_t c;
    c = '0;
    if (x > win_right) c = OC_RIGHT;
    else if (x < win_left) c = OC_LEFT;
    if (y > win_top) c = c | OC_TOP;
    else if (y < win_bottom) c = c | OC_BOTTOM;
    return c;
  endfunction

  // base + trunc(d * b / den), quotient capped, result held to the coordinate range
  function automatic longint clip_shift(longint base, longint d, longint b, longint den);
    longint unsigned q;
    bit              neg;
    longint          r;
    if (den == 0) return base;
    q = (magnitude(d) * magnitude(b)) / magnitude(den);
    if (q > QUOT_CAP) q = QUOT_CAP;
    neg = ((d < 0) != (b < 0)) != (den < 0);
    r = neg ? base - longint'(q) : base + longint'(q);
    return clamp_coord(r);
  endfunction

  function automatic bit lone_bit(outcode_t c);
    return (c != 0) && ((c & (c - 1'b1)) == 0);
  endfunction

  // (x1,y1) is the end that gets moved onto the window boundary.
  function automatic bit edge_touches_window(longint x1, longint y1, longint x2, longint y2);
    outcode_t c1, c2;
    for (int pass = 0; pass < PASS_LIMIT; pass++) begin
      c1 = window_code(x1, y1);
      c2 = window_code(x2, y2);
      if ((c1 & c2) != 0) return 1'b0;
      if (c1 == 0 || c2 == 0) return 1'b1;
      if (lone_bit(c1) && lone_bit(c2) &&
          ((c1 ^ c2) == (OC_LEFT | OC_RIGHT) || (c1 ^ c2) == (OC_TOP | OC_BOTTOM)))
        return 1'b1;
      if (c1 & OC_TOP) begin
        x1 = clip_shift(x1, x2 - x1, win_top - y1, y2 - y1);
        y1 = win_top;
      end else if (c1 & OC_BOTTOM) begin
        x1 = clip_shift(x1, x2 - x1, win_bottom - y1, y2 - y1);
        y1 = win_bottom;
      end else if (c1 & OC_RIGHT) begin
        y1 = clip_shift(y1, y2 - y1, win_right - x1, x2 - x1);
        x1 = win_right;
      end else begin
        y1 = clip_shift(y1, y2 - y1, win_left - x1, x2 - x1);
        x1 = win_left;
      end
    end
    // Never settled: counts as a miss.
    return 1'b0;
  endfunction

  // Advance the polyline by one vertex; returns 1 when the vertex closes a figure.
  function automatic bit predict_vertex(longint x, longint y, bit closing, output bit any_hit);
    any_hit = 1'b0;
    if (!poly_open) begin
      poly_first_x = x;
      poly_first_y = y;
      poly_open = 1'b1;
    end else if (!poly_hit && edge_touches_window(x, y, poly_prev_x, poly_prev_y)) begin
      poly_hit = 1'b1;
    end
    poly_prev_x = x;
    poly_prev_y = y;
    if (!closing) return 1'b0;
    if (!poly_hit && edge_touches_window(poly_first_x, poly_first_y, x, y))
      poly_hit = 1'b1;
    any_hit = poly_hit;
    poly_open = 1'b0;
    poly_hit = 1'b0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------

  // Setup cycle, then access cycle; the register takes the value at the access edge.
  task automatic apb_write(reg_idx_t idx, longint value);
    logic signed [COORD_W-1:0] v;
    v = value[COORD_W-1:0];
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{(APB_DATA_BITS-COORD_W){v[COORD_W-1]}}, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_LEFT:   win_left   = v;
      REG_BOTTOM: win_bottom = v;
      REG_RIGHT:  win_right  = v;
      REG_TOP:    win_top    = v;
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_window(longint l, longint b, longint r, longint t);
    apb_write(REG_LEFT, l);
    apb_write(REG_BOTTOM, b);
    apb_write(REG_RIGHT, r);
    apb_write(REG_TOP, t);
  endtask

  // ---------------------------------------------------------------------------
  // Vertex requests
  // ---------------------------------------------------------------------------

  // Offer one vertex, hold it until taken, then book the expected hit if it closes.
  task automatic offer_vertex(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                              bit closing, bit known, bit known_hit);
    int k;
    bit has_result;
    bit predicted;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      k = $urandom_range(1, 4);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (k - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    vertex_x    <= x;
    vertex_y    <= y;
    last_vertex <= closing;
    do @(posedge clk); while (in_stall);
    has_result = predict_vertex(x, y, closing, predicted);
    if (has_result) pending_hits.push_back(known ? known_hit : predicted);
  endtask

  // Drop valid, wait out every owed hit, then let a vertex still in work finish.
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Random stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic longint rand_coord();
    logic signed [COORD_W-1:0] v;
    v = $urandom;
    return v;
  endfunction

  // A coordinate around the span [a,b], with extra weight on the exact bounds.
  function automatic longint near_coord(longint a, longint b);
    longint lo, hi, pad, from, upto;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    case ($urandom_range(0, 11))
      0: return lo;
      1: return hi;
      2: return clamp_coord(lo - 1);
      3: return clamp_coord(hi + 1);
      default: begin
        pad  = (hi - lo) / 2 + 40;
        from = clamp_coord(lo - pad);
        upto = clamp_coord(hi + pad);
        return from + longint'($urandom_range(0, int'(upto - from)));
      end
    endcase
  endfunction

  // Pick the window for a random phase; the first few cover the extremes.
  task automatic pick_window(int phase);
    longint cx, cy, hw, hh;
    int     kind;
    cx = rand_coord();
    cy = rand_coord();
    hw = $urandom_range(0, 3000);
    hh = $urandom_range(0, 3000);
    kind = (phase < 4) ? phase : $urandom_range(3, 9);
    case (kind)
      0: load_window(COORD_LO, COORD_LO, COORD_HI, COORD_HI);
      1: load_window(clamp_coord(cx + hw + 1), clamp_coord(cy + hh + 1),
                     clamp_coord(cx - hw - 1), clamp_coord(cy - hh - 1));
      2: load_window(COORD_LO, COORD_HI, COORD_LO, COORD_HI);
      3: load_window(cx, clamp_coord(cy - hh), cx, clamp_coord(cy + hh));
      4: load_window(COORD_HI, cy, COORD_HI, cy);
      default: load_window(clamp_coord(cx - hw), clamp_coord(cy - hh),
                           clamp_coord(cx + hw), clamp_coord(cy + hh));
    endcase
  endtask

  // Closed polylines, mostly short, with vertices scattered around the window.
  task automatic run_polylines(int budget);
    int sent, len, i;
    bit wild;
    logic signed [COORD_W-1:0] x, y;
    sent = 0;
    while (sent < budget) begin
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 14) : $urandom_range(1, 5);
      wild = ($urandom_range(0, 3) == 0);
      for (i = 0; i < len; i++) begin
        if (wild) begin
          x = $urandom;
          y = $urandom;
        end else begin
          x = near_coord(win_left, win_right);
          y = near_coord(win_bottom, win_top);
        end
        offer_vertex(x, y, i == len - 1, 1'b0, 1'b0);
      end
      sent += len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall at random, and once hold off for a long stretch
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (hold_pending && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Compare every accepted result with the oldest owed hit.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_hits.size() == 0) begin
        faults++;
        $display("%0t: unexpected result, expected none, actual hit=%0b", $time, hit);
      end else if (hit !== pending_hits[0]) begin
        faults++;
        $display("%0t: hit mismatch, expected %0b, actual %0b", $time, pending_hits[0], hit);
        void'(pending_hits.pop_front());
      end else begin
        void'(pending_hits.pop_front());
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results owed", $time, pending_hits.size());
      $display("** polyline_rect_hit_test: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid     = 1'b0;
    vertex_x     = '0;
    vertex_y     = '0;
    last_vertex  = 1'b0;
    out_stall    = 1'b0;
    faults       = 0;
    cycle_count  = 0;
    gap_pct      = 0;
    stall_pct    = 0;
    hold_pending = 1'b0;
    hold_taken   = 1'b0;
    hold_left    = 0;
    win_left     = 0;
    win_bottom   = 0;
    win_right    = 0;
    win_top      = 0;
    poly_first_x = 0;
    poly_first_y = 0;
    poly_prev_x  = 0;
    poly_prev_y  = 0;
    poly_open    = 1'b0;
    poly_hit     = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed walk: starts on the reset window, then the extremes.
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_RECT) begin
        settle_block();
        load_window(plan[i].a, plan[i].b, plan[i].c, plan[i].d);
      end else begin
        offer_vertex(plan[i].a[COORD_W-1:0], plan[i].b[COORD_W-1:0], plan[i].last,
                     plan[i].known, plan[i].hit);
      end
    end

    // Random phases: new window each time, cycling through the idle patterns.
    for (int p = 0; p < PHASES; p++) begin
      settle_block();
      pick_window(p);
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 69; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 69; end
        default: begin gap_pct = 33; stall_pct = 33; end
      endcase
      // Back up the result side while vertices keep coming, so the input stalls.
      if (p == 4) hold_pending = 1'b1;
      run_polylines(PHASE_VERTICES);
    end

    settle_block();
    if (faults == 0)
      $display("** polyline_rect_hit_test: PASSED **");
    else
      $display("** polyline_rect_hit_test: FAILED **");
    $finish;
  end

endmodule
